// ----- design/erld_pkg.sv -----
// ----------------------------------------------------------------------------
// erld_pkg: shared types and codes of the extent run-list decoder
// Payload structs of both channels, the queue entry passed from the byte
// classifier to the run builder, and the status and entry kind codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package erld_pkg;

  // Widest length or offset field a header may announce, in bytes
  localparam int unsigned MAX_FIELD_BYTES = 8;

  // Default depth of the queue between classifier and run builder
  localparam int unsigned QUEUE_DEPTH = 4;

  // Result status codes
  localparam logic [2:0] ST_RUN       = 3'd0;
  localparam logic [2:0] ST_END       = 3'd1;
  localparam logic [2:0] ST_BAD_LEN   = 3'd2;
  localparam logic [2:0] ST_BAD_LCN   = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;
  localparam logic [2:0] ST_TOO_WIDE  = 3'd5;

  // Kind of a queued beat
  localparam logic [1:0] KIND_HDR   = 2'd0;  // header opening a record
  localparam logic [1:0] KIND_FIELD = 2'd1;  // length or offset byte
  localparam logic [1:0] KIND_END   = 2'd2;  // zero header, end of list
  localparam logic [1:0] KIND_ERR   = 2'd3;  // header rejected by classifier

  // lcn reported with the end of list
  localparam logic [63:0] LCN_END_MARK = 64'hFFFF_FFFF_FFFF_FFFD;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [62:0]        run_vcn;
    logic signed [63:0] run_lcn;
    logic [62:0]        run_length;
  } out_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] status;     // error code for KIND_ERR
    logic       first;      // beat opens a new list
    logic       last;       // beat is the final byte of the region
    logic [7:0] data;
    logic [3:0] idx;        // field byte index within the record
    logic [3:0] len_cnt;    // length bytes of the record
    logic [3:0] off_cnt;    // offset bytes of the record
  } item_t;

endpackage

// ----- design/erld_front.sv -----
// ----------------------------------------------------------------------------
// erld_front: byte classifier
// Tracks the record structure of the byte stream, decodes header bytes and
// tags each beat with its kind and field position for the run builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module erld_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  erld_pkg::in_t  in_data,
  output logic           push,
  output erld_pkg::item_t item
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_FIELD  = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [3:0] lc_r, lc_nxt;
  logic [3:0] oc_r, oc_nxt;

  logic [1:0] phase_eff;
  logic [3:0] hdr_lc;
  logic [3:0] hdr_oc;
  logic [4:0] idx_inc;
  logic [4:0] rec_len;
  logic       accept;

  assign accept    = in_valid && in_ready;
  assign phase_eff = in_data.first_byte ? PH_HEADER : phase_r;
  assign hdr_lc    = in_data.data_byte[3:0];
  assign hdr_oc    = in_data.data_byte[7:4];
  assign idx_inc   = {1'b0, idx_r} + 5'd1;
  assign rec_len   = {1'b0, lc_r} + {1'b0, oc_r};

  // Classify the beat and advance the record position
  always_comb begin
    phase_nxt    = phase_r;
    idx_nxt      = idx_r;
    lc_nxt       = lc_r;
    oc_nxt       = oc_r;
    push         = 1'b0;
    item         = '0;
    item.first   = in_data.first_byte;
    item.last    = in_data.last_byte;
    item.data    = in_data.data_byte;
    item.idx     = idx_r;
    item.len_cnt = lc_r;
    item.off_cnt = oc_r;
    if (accept) begin
      unique case (phase_eff)
        PH_HEADER: begin
          push      = 1'b1;
          phase_nxt = PH_DONE;
          priority if (in_data.data_byte == 8'd0) begin
            item.kind = erld_pkg::KIND_END;
          end else if (hdr_lc == 4'd0) begin
            item.kind   = erld_pkg::KIND_ERR;
            item.status = erld_pkg::ST_BAD_LEN;
          end else if (hdr_lc > 4'(erld_pkg::MAX_FIELD_BYTES) ||
                       hdr_oc > 4'(erld_pkg::MAX_FIELD_BYTES)) begin
            item.kind   = erld_pkg::KIND_ERR;
            item.status = erld_pkg::ST_TOO_WIDE;
          end else if (in_data.last_byte) begin
            item.kind   = erld_pkg::KIND_ERR;
            item.status = erld_pkg::ST_TRUNCATED;
          end else begin
            item.kind = erld_pkg::KIND_HDR;
            phase_nxt = PH_FIELD;
            idx_nxt   = 4'd0;
            lc_nxt    = hdr_lc;
            oc_nxt    = hdr_oc;
          end
        end
        PH_FIELD: begin
          push      = 1'b1;
          item.kind = erld_pkg::KIND_FIELD;
          priority if (in_data.last_byte) begin
            phase_nxt = PH_DONE;
          end else if (idx_inc == rec_len) begin
            phase_nxt = PH_HEADER;
            idx_nxt   = 4'd0;
          end else begin
            idx_nxt = idx_inc[3:0];
          end
        end
        default: begin
          // finished list: drop beats until a new list opens
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      idx_r   <= 4'd0;
      lc_r    <= 4'd0;
      oc_r    <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      lc_r    <= lc_nxt;
      oc_r    <= oc_nxt;
    end
  end

endmodule

// ----- design/erld_fifo.sv -----
// ----------------------------------------------------------------------------
// erld_fifo: beat queue
// Small first-in first-out queue of classified beats between the byte
// classifier and the run builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module erld_fifo #(
  parameter int unsigned DEPTH = erld_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  erld_pkg::item_t push_item,
  input  logic            pop,
  output erld_pkg::item_t head,
  output logic            empty,
  output logic            full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  erld_pkg::item_t mem [DEPTH];

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign empty = (count_r == CW'(0));
  assign full  = (count_r == CW'(DEPTH));
  assign head  = mem[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill count beyond depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push)
    else $error("push into a full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("pop from an empty queue");
`endif

endmodule

// ----- design/erld_back.sv -----
// ----------------------------------------------------------------------------
// erld_back: run builder
// Assembles length and offset fields, keeps the running vcn and lcn, checks
// each record and drives the registered result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module erld_back (
  input  logic            clk,
  input  logic            rst_n,
  input  erld_pkg::item_t head,
  input  logic            empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output erld_pkg::out_t  out_data
);

  logic [62:0] vcn_r, vcn_nxt;
  logic [63:0] lcn_r, lcn_nxt;
  logic [63:0] len_r, len_nxt;
  logic [63:0] delta_r, delta_nxt;
  logic        dead_r, dead_nxt;
  logic        out_valid_r, out_valid_nxt;
  erld_pkg::out_t out_r, out_nxt;

  logic [62:0] vcn_base;
  logic [63:0] lcn_base;
  logic        dead_eff;
  logic        can_go;
  logic [4:0]  idx_inc;
  logic [4:0]  rec_len;
  logic        len_done;
  logic        rec_done;
  logic        in_len;
  logic [2:0]  off_pos;
  logic [63:0] len_merged;
  logic [63:0] len_cur;
  logic [63:0] delta_merged;
  logic [63:0] vcn_sum;
  logic [63:0] lcn_sum;
  logic        lcn_bad;

  // Sign-extend a field of n bytes to 64 bits
  function automatic logic [63:0] sext(input logic [63:0] v, input logic [3:0] n);
    logic [63:0] r;
    logic        s;
    r = v;
    s = v[6'({n[2:0], 3'b000} - 6'd1)];
    if (n != 4'd0 && n < 4'd8) begin
      for (int k = 0; k < 8; k++) begin
        if (4'(k) >= n) begin
          r[8*k +: 8] = {8{s}};
        end
      end
    end
    return r;
  endfunction

  assign can_go   = !out_valid_r || out_ready;
  assign pop      = !empty && can_go;
  assign vcn_base = head.first ? '0 : vcn_r;
  assign lcn_base = head.first ? '0 : lcn_r;
  assign dead_eff = head.first ? 1'b0 : dead_r;

  assign idx_inc  = {1'b0, head.idx} + 5'd1;
  assign rec_len  = {1'b0, head.len_cnt} + {1'b0, head.off_cnt};
  assign in_len   = head.idx < head.len_cnt;
  assign len_done = (idx_inc == {1'b0, head.len_cnt});
  assign rec_done = (idx_inc == rec_len);
  assign off_pos  = 3'(head.idx - head.len_cnt);

  // Merge the beat into the length and offset fields
  always_comb begin
    len_merged   = len_r;
    delta_merged = delta_r;
    if (in_len) begin
      len_merged[8*head.idx[2:0] +: 8] = head.data;
    end else begin
      delta_merged[8*off_pos +: 8] = head.data;
    end
  end

  assign len_cur = len_done ? sext(len_merged, head.len_cnt) : len_merged;
  assign vcn_sum = {1'b0, vcn_base} + len_cur;
  assign lcn_sum = lcn_base + sext(delta_merged, head.off_cnt);
  assign lcn_bad = lcn_sum[63] && (lcn_sum != '1);

  // Execute the head beat and load the result register
  always_comb begin
    vcn_nxt       = vcn_r;
    lcn_nxt       = lcn_r;
    len_nxt       = len_r;
    delta_nxt     = delta_r;
    dead_nxt      = dead_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (can_go) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      vcn_nxt  = vcn_base;
      lcn_nxt  = lcn_base;
      dead_nxt = dead_eff;
      out_nxt  = '0;
      if (!dead_eff) begin
        unique case (head.kind)
          erld_pkg::KIND_END: begin
            dead_nxt         = 1'b1;
            out_valid_nxt    = 1'b1;
            out_nxt.status   = erld_pkg::ST_END;
            out_nxt.run_vcn  = vcn_base;
            out_nxt.run_lcn  = erld_pkg::LCN_END_MARK;
          end
          erld_pkg::KIND_ERR: begin
            dead_nxt       = 1'b1;
            out_valid_nxt  = 1'b1;
            out_nxt.status = head.status;
          end
          erld_pkg::KIND_HDR: begin
            len_nxt   = '0;
            delta_nxt = '0;
          end
          default: begin
            len_nxt   = len_cur;
            delta_nxt = delta_merged;
            priority if (len_done && len_cur[63]) begin
              dead_nxt       = 1'b1;
              out_valid_nxt  = 1'b1;
              out_nxt.status = erld_pkg::ST_BAD_LEN;
            end else if (len_done && vcn_sum[63]) begin
              dead_nxt       = 1'b1;
              out_valid_nxt  = 1'b1;
              out_nxt.status = erld_pkg::ST_TOO_WIDE;
            end else if (rec_done && head.off_cnt != 4'd0 && lcn_bad) begin
              dead_nxt       = 1'b1;
              out_valid_nxt  = 1'b1;
              out_nxt.status = erld_pkg::ST_BAD_LCN;
            end else if (head.last) begin
              dead_nxt       = 1'b1;
              out_valid_nxt  = 1'b1;
              out_nxt.status = erld_pkg::ST_TRUNCATED;
            end else if (rec_done) begin
              if (head.off_cnt != 4'd0) begin
                lcn_nxt = lcn_sum;
              end
              vcn_nxt = vcn_sum[62:0];
              // drop zero-length runs, the lcn still moves on
              if (len_cur != '0) begin
                out_valid_nxt      = 1'b1;
                out_nxt.status     = erld_pkg::ST_RUN;
                out_nxt.run_vcn    = vcn_base;
                out_nxt.run_lcn    = (head.off_cnt != 4'd0) ? lcn_sum : '1;
                out_nxt.run_length = len_cur[62:0];
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcn_r       <= '0;
      lcn_r       <= '0;
      len_r       <= '0;
      delta_r     <= '0;
      dead_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vcn_r       <= vcn_nxt;
      lcn_r       <= lcn_nxt;
      len_r       <= len_nxt;
      delta_r     <= delta_nxt;
      dead_r      <= dead_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_err_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != erld_pkg::ST_RUN && out_r.status != erld_pkg::ST_END
    |-> out_r.run_vcn == '0 && out_r.run_lcn == '0 && out_r.run_length == '0)
    else $error("error beat carries non-zero fields");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == erld_pkg::ST_RUN |-> out_r.run_length != '0)
    else $error("zero-length run emitted");

  a_dead_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !dead_eff && (head.kind == erld_pkg::KIND_END || head.kind == erld_pkg::KIND_ERR)
    |=> dead_r && out_valid_r)
    else $error("list not closed after end or error");
`endif

endmodule

// ----- design/extent_run_list_decoder_top.sv -----
// ----------------------------------------------------------------------------
// Extent run-list decoder
// Input channel in_*: one run-list byte per beat with first/last markers.
// Output channel out_*: one beat per decoded run, end of list or error.
// A classifier decodes headers and tags field bytes, a queue decouples it
// from the run builder, which assembles fields and keeps vcn and lcn.
// Throughput: one byte per cycle while the queue is not full; the queue
// fills when a stalled receiver holds the result register.
// A result beat is loaded into the result register once its last input
// byte has passed through the queue.
// Bytes that produce no result (headers, inner field bytes, zero-length
// runs, bytes after an end or error) are consumed without an output beat.
// After an end of list or an error, bytes are ignored until first_byte.
// Reset (rst_n low, synchronous) empties the queue, clears vcn and lcn and
// drops any pending result beat.
// A stalled receiver holds the result register; the queue keeps accepting
// bytes until it fills, then in_ready falls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module extent_run_list_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = erld_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  erld_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output erld_pkg::out_t out_data
);

  logic            push;
  logic            pop;
  logic            empty;
  logic            full;
  erld_pkg::item_t push_item;
  erld_pkg::item_t head;

  assign in_ready = !full;

  // Classify incoming bytes
  erld_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (push),
    .item     (push_item)
  );

  // Queue classified beats
  erld_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  // Build runs and drive results
  erld_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
